@@ sv/eac_pkg.sv @@
`default_nettype none
package eac_pkg;

   localparam logic [7:0] CHAR_AT   = 8'h40;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   localparam int unsigned LEN_WIDTH = 7;
   localparam logic [LEN_WIDTH-1:0] LEN_SAT            = '1;
   localparam logic [LEN_WIDTH-1:0] MAX_LOCAL_RESET    = 7'd64;
   localparam logic [LEN_WIDTH-1:0] MAX_DOMAIN_RESET   = 7'd63;

   typedef enum logic {
      REG_MAX_LOCAL  = 1'b0,
      REG_MAX_DOMAIN = 1'b1
   } reg_index_type;

   // Classified byte handed from the front to the back.
   typedef struct packed {
      logic is_at;
      logic is_dot;
      logic domain_ok;
      logic local_ok;
      logic last;
   } beat_type;

   function automatic logic is_local_special(input logic [7:0] c);
      logic hit;
      begin
         case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2F,
            8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E:
               hit = 1'b1;
            default:
               hit = 1'b0;
         endcase
         return hit;
      end
   endfunction

   function automatic beat_type classify(input logic [7:0] c, input logic last);
      beat_type b;
      logic     alnum;
      begin
         alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h30 && c <= 8'h39);
         b.is_at     = (c == CHAR_AT);
         b.is_dot    = (c == CHAR_DOT);
         b.domain_ok = alnum || (c == CHAR_DASH) || (c == CHAR_DOT);
         b.local_ok  = alnum || (c == CHAR_DASH) || (c == CHAR_DOT) ||
                       is_local_special(c);
         b.last      = last;
         return b;
      end
   endfunction

endpackage
`default_nettype wire

@@ sv/eac_front.sv @@
`default_nettype none
module eac_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_char_in,
   input  wire logic              req_last_char,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output eac_pkg::beat_type      out_beat
);

   logic               valid_ff, valid_in;
   eac_pkg::beat_type  beat_ff, beat_in;
   logic               accept;

   assign req_stall = valid_ff && out_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (accept) begin
         valid_in = 1'b1;
         beat_in  = eac_pkg::classify(req_char_in, req_last_char);
      end else if (valid_ff && !out_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule
`default_nettype wire

@@ sv/eac_queue.sv @@
`default_nettype none
module eac_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire eac_pkg::beat_type in_beat,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output eac_pkg::beat_type      out_beat
);

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   eac_pkg::beat_type       slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]    count_ff, count_in;
   logic                    push, pop;

   assign in_stall  = (count_ff == FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_beat  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_beat;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count exceeds depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

endmodule
`default_nettype wire

@@ sv/eac_back.sv @@
`default_nettype none
module eac_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [eac_pkg::LEN_WIDTH-1:0]         max_local,
   input  wire logic [eac_pkg::LEN_WIDTH-1:0]         max_domain,
   input  wire logic                                  in_valid,
   output logic                                       in_stall,
   input  wire eac_pkg::beat_type                     in_beat,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_address_valid
);

   logic [1:0]                       at_signs_ff, at_signs_in;
   logic [eac_pkg::LEN_WIDTH-1:0]    local_count_ff, local_count_in;
   logic [eac_pkg::LEN_WIDTH-1:0]    domain_count_ff, domain_count_in;
   logic                             prev_dot_ff, prev_dot_in;
   logic                             broken_ff, broken_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             verdict_ff, verdict_in;

   logic                             take;
   logic                             in_domain;
   logic [eac_pkg::LEN_WIDTH-1:0]    count, limit, count_next;
   logic [1:0]                       at_next;
   logic [eac_pkg::LEN_WIDTH-1:0]    local_next, domain_next;
   logic                             dot_next, broken_next, char_ok, verdict;

   assign in_stall = rsp_valid_ff && rsp_stall;
   assign take     = in_valid && !in_stall;

   assign in_domain  = (at_signs_ff != 2'd0);
   assign count      = in_domain ? domain_count_ff : local_count_ff;
   assign limit      = in_domain ? max_domain : max_local;
   assign char_ok    = in_domain ? in_beat.domain_ok : in_beat.local_ok;
   assign count_next = (count == eac_pkg::LEN_SAT) ? count : count + 1'b1;

   // Fold one byte into the running per-address state.
   always_comb begin
      at_next     = at_signs_ff;
      local_next  = local_count_ff;
      domain_next = domain_count_ff;
      dot_next    = prev_dot_ff;
      broken_next = broken_ff;
      if (in_beat.is_at) begin
         if (at_signs_ff != 2'd0 || local_count_ff == '0 || prev_dot_ff) begin
            broken_next = 1'b1;
         end
         if (at_signs_ff != 2'd3) begin
            at_next = at_signs_ff + 1'b1;
         end
         dot_next = 1'b0;
      end else begin
         if (!char_ok || count >= limit ||
             (in_beat.is_dot && (count == '0 || prev_dot_ff))) begin
            broken_next = 1'b1;
         end
         if (in_domain) begin
            domain_next = count_next;
         end else begin
            local_next = count_next;
         end
         dot_next = in_beat.is_dot;
      end
      verdict = !broken_next && (at_next == 2'd1) && (local_next != '0) &&
                (domain_next != '0) && !dot_next;
   end

   always_comb begin
      at_signs_in     = at_signs_ff;
      local_count_in  = local_count_ff;
      domain_count_in = domain_count_ff;
      prev_dot_in     = prev_dot_ff;
      broken_in       = broken_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      verdict_in      = verdict_ff;
      if (take) begin
         if (in_beat.last) begin
            // Verdict out, start the next address clean.
            at_signs_in     = 2'd0;
            local_count_in  = '0;
            domain_count_in = '0;
            prev_dot_in     = 1'b0;
            broken_in       = 1'b0;
            rsp_valid_in    = 1'b1;
            verdict_in      = verdict;
         end else begin
            at_signs_in     = at_next;
            local_count_in  = local_next;
            domain_count_in = domain_next;
            prev_dot_in     = dot_next;
            broken_in       = broken_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_signs_ff     <= 2'd0;
         local_count_ff  <= '0;
         domain_count_ff <= '0;
         prev_dot_ff     <= 1'b0;
         broken_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         at_signs_ff     <= at_signs_in;
         local_count_ff  <= local_count_in;
         domain_count_ff <= domain_count_in;
         prev_dot_ff     <= prev_dot_in;
         broken_ff       <= broken_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_address_valid = verdict_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && in_beat.last) |=> (at_signs_ff == 2'd0 && local_count_ff == '0 &&
                                  domain_count_ff == '0 && !broken_ff))
      else $error("address state not cleared after last beat");

   a_verdict_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && in_beat.last) |=> rsp_valid_ff)
      else $error("no verdict after last beat");

endmodule
`default_nettype wire

@@ sv/email_address_syntax_checker.sv @@
// Email address syntax checker.
// An address arrives one byte per beat on the req_ channel (req_char_in), with
// req_last_char high on its final byte. After the final byte one verdict beat
// leaves on the rsp_ channel: rsp_address_valid is 1 when the address has one
// '@', both parts within their length limits, no leading, trailing or doubled
// dots, and only allowed characters in each part. Other beats give no result.
// The part length limits sit in two APB registers (byte address 0: local part,
// byte address 4: domain part, 7 bits each); write them only while idle.
// Throughput is one byte per cycle while rsp_stall is low; the per-byte class
// check sits in the front register and the state update in the back stage.
// From the accepted last byte the verdict passes the front register, the
// classified-byte queue and the verdict register.
// Synchronous reset clears all per-address state and the queue and restores the
// limits to 64 and 63; no setup pass follows, so bytes are taken at once.
// When rsp_stall holds the verdict, the back stage stops, the queue fills, and
// then req_stall rises; bytes already accepted are kept, none are dropped.
`default_nettype none
module email_address_syntax_checker #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_address_valid,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [eac_pkg::LEN_WIDTH-1:0] max_local_ff, max_local_in;
   logic [eac_pkg::LEN_WIDTH-1:0] max_domain_ff, max_domain_in;
   eac_pkg::reg_index_type        reg_sel;
   logic                          wr_en;

   logic               fq_valid, fq_stall;
   eac_pkg::beat_type  fq_beat;
   logic               qb_valid, qb_stall;
   eac_pkg::beat_type  qb_beat;

   assign pready  = 1'b1;
   assign reg_sel = eac_pkg::reg_index_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      max_local_in  = max_local_ff;
      max_domain_in = max_domain_ff;
      if (wr_en) begin
         case (reg_sel)
            eac_pkg::REG_MAX_LOCAL:  max_local_in  = pwdata[eac_pkg::LEN_WIDTH-1:0];
            eac_pkg::REG_MAX_DOMAIN: max_domain_in = pwdata[eac_pkg::LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         eac_pkg::REG_MAX_LOCAL:
            prdata = {{(32 - eac_pkg::LEN_WIDTH){1'b0}}, max_local_ff};
         eac_pkg::REG_MAX_DOMAIN:
            prdata = {{(32 - eac_pkg::LEN_WIDTH){1'b0}}, max_domain_ff};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_local_ff  <= eac_pkg::MAX_LOCAL_RESET;
         max_domain_ff <= eac_pkg::MAX_DOMAIN_RESET;
      end else begin
         max_local_ff  <= max_local_in;
         max_domain_ff <= max_domain_in;
      end
   end

   eac_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_in   (req_char_in),
      .req_last_char (req_last_char),
      .out_valid     (fq_valid),
      .out_stall     (fq_stall),
      .out_beat      (fq_beat)
   );

   eac_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_stall  (fq_stall),
      .in_beat   (fq_beat),
      .out_valid (qb_valid),
      .out_stall (qb_stall),
      .out_beat  (qb_beat)
   );

   eac_back u_back (
      .clock             (clock),
      .reset             (reset),
      .max_local         (max_local_ff),
      .max_domain        (max_domain_ff),
      .in_valid          (qb_valid),
      .in_stall          (qb_stall),
      .in_beat           (qb_beat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_address_valid (rsp_address_valid)
   );

endmodule
`default_nettype wire
